// ----- rtl/drum_step_sequencer_defines.svh -----
// Assertion helpers used by the sequencer control (dss_ctrl).
`ifndef DRUM_STEP_SEQUENCER_DEFINES_SVH
`define DRUM_STEP_SEQUENCER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/dss_pkg.sv -----
`default_nettype none

package dss_pkg;

  localparam int STEP_COUNT  = 8;
  localparam int TRACK_COUNT = 4;

  localparam int STEP_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int TRK_W  = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

  // Port field widths
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int MASK_OUT_W = 4;
  localparam int STEP_OUT_W = 3;
  localparam int TRK_OUT_W  = 2;
  localparam int TEMPO_W    = 8;

  // Widened views so the port fields can be taken as low slices
  localparam int MASK_EXT_W = (TRACK_COUNT > MASK_OUT_W) ? TRACK_COUNT : MASK_OUT_W;
  localparam int TRK_EXT_W  = (TRK_W > TRK_OUT_W) ? TRK_W : TRK_OUT_W;
  localparam int STEP_EXT_W = (STEP_W > STEP_OUT_W) ? STEP_W : STEP_OUT_W;

  localparam int PERIOD_W  = 9;
  localparam int ELAPSED_W = 10;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 8'd60;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 8'd180;
  localparam logic [TEMPO_W-1:0] TEMPO_STEP  = 8'd5;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 8'd100;
  localparam logic [TEMPO_W-1:0] TEMPO_FLOOR = TEMPO_MIN + TEMPO_STEP;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd300;

  // step period = (60000 / bpm) / 2 = 30000 / bpm
  localparam int MS_PER_MINUTE = 60000;
  localparam int DIVIDEND_W    = 15;
  localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(MS_PER_MINUTE / 2);
  localparam int DIV_CNT_W = $clog2(DIVIDEND_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  localparam logic [7:0] DEFAULT_ROWS [8] = '{
    8'h11, 8'h44, 8'hD5, 8'h49, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_TOGGLE     = 3'd1,
    OP_START_STOP = 3'd2,
    OP_TRACK_UP   = 3'd3,
    OP_TRACK_DOWN = 3'd4,
    OP_TEMPO_UP   = 3'd5,
    OP_TEMPO_DOWN = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic tempo_op;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/dss_ctrl.sv -----
`default_nettype none

`include "drum_step_sequencer_defines.svh"

module dss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire dss_pkg::status_t status_i,
  output dss_pkg::cmd_t         cmd_o
);

  dss_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dss_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dss_pkg::ST_EXEC;
      end
      dss_pkg::ST_EXEC: begin
        state_d = status_i.tempo_op ? dss_pkg::ST_DIV : dss_pkg::ST_FINISH;
      end
      dss_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = dss_pkg::ST_FINISH;
      end
      dss_pkg::ST_FINISH: begin
        if (out_free) state_d = dss_pkg::ST_IDLE;
      end
      default: state_d = dss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      dss_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dss_pkg::ST_EXEC: begin
        cmd_o.exec      = 1'b1;
        cmd_o.div_start = status_i.tempo_op;
      end
      dss_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      dss_pkg::ST_FINISH: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold the result until its transfer; a new load may replace it in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dss_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DSS_ASSERT(a_accept_to_exec, in_valid_i && in_ready_o |=> state_q == dss_pkg::ST_EXEC, "accepted item did not enter execute")
  `DSS_ASSERT(a_tempo_to_div, state_q == dss_pkg::ST_EXEC && status_i.tempo_op |=> state_q == dss_pkg::ST_DIV, "tempo change skipped the period divide")
  `DSS_ASSERT(a_load_sets_valid, cmd_o.load_out |=> out_valid_o, "loaded result not presented")
  `DSS_ASSERT_ALWAYS(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result register overwritten before transfer")

endmodule

`default_nettype wire

// ----- rtl/dss_datapath.sv -----
`default_nettype none

module dss_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [dss_pkg::OP_W-1:0]           operation_i,
  input  wire logic [dss_pkg::IDX_W-1:0]          step_index_i,
  input  wire dss_pkg::cmd_t                      cmd_i,
  output dss_pkg::status_t                        status_o,
  output logic      [dss_pkg::MASK_OUT_W-1:0]     trigger_mask_o,
  output logic      [dss_pkg::STEP_OUT_W-1:0]     current_step_o,
  output logic                                    running_o,
  output logic      [dss_pkg::TRK_OUT_W-1:0]      selected_track_o,
  output logic      [dss_pkg::TEMPO_W-1:0]        tempo_bpm_o
);

  localparam int NT = dss_pkg::TRACK_COUNT;
  localparam int NS = dss_pkg::STEP_COUNT;
  localparam int SW = dss_pkg::STEP_W;
  localparam int TW = dss_pkg::TRK_W;

  // Captured item
  dss_pkg::op_e             op_q;
  logic [dss_pkg::IDX_W-1:0] idx_q;

  // Sequencer state
  logic [NS-1:0]                     pattern_q [NT];
  logic [NS-1:0]                     pattern_d [NT];
  logic [dss_pkg::TEMPO_W-1:0]       tempo_q, tempo_d;
  logic [dss_pkg::PERIOD_W-1:0]      period_q;
  logic [TW-1:0]                     cursor_q, cursor_d;
  logic [SW-1:0]                     pos_q, pos_d;
  logic                              running_q, running_d;
  logic [dss_pkg::ELAPSED_W-1:0]     elapsed_q, elapsed_d;
  logic [NT-1:0]                     trig_q, trig_d;

  // Period divider
  logic [dss_pkg::TEMPO_W-1:0]       rem_q, rem_d;
  logic [dss_pkg::DIVIDEND_W-1:0]    dq_q, dq_d;
  logic [dss_pkg::DIV_CNT_W-1:0]     div_cnt_q;
  logic [dss_pkg::TEMPO_W:0]         trial;
  logic [dss_pkg::TEMPO_W:0]         trial_diff;
  logic                              trial_ge;

  // Per-operation helpers
  logic [dss_pkg::ELAPSED_W-1:0]     elapsed_inc;
  logic [SW-1:0]                     pos_wrap;
  logic [NT-1:0]                     col_mask;
  logic [SW-1:0]                     idx_s;
  logic                              idx_ok;
  logic                              new_bit;
  logic [NT-1:0]                     cursor_onehot;
  logic [dss_pkg::TEMPO_W:0]         tempo_sum;

  // Output register
  logic [dss_pkg::MASK_EXT_W-1:0]    mask_ext;
  logic [dss_pkg::TRK_EXT_W-1:0]     trk_ext;
  logic [dss_pkg::STEP_EXT_W-1:0]    step_ext;

  assign status_o.tempo_op = (op_q == dss_pkg::OP_TEMPO_UP) || (op_q == dss_pkg::OP_TEMPO_DOWN);
  assign status_o.div_last = (div_cnt_q == dss_pkg::DIV_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= dss_pkg::op_e'(operation_i);
      idx_q <= step_index_i;
    end
  end

  assign elapsed_inc = (elapsed_q == dss_pkg::ELAPSED_MAX) ? elapsed_q
                                                           : elapsed_q + 1'b1;
  assign pos_wrap    = (pos_q == SW'(NS - 1)) ? '0 : pos_q + 1'b1;

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      col_mask[t]      = pattern_q[t][pos_wrap];
      cursor_onehot[t] = (cursor_q == TW'(t));
    end
  end

  assign idx_s     = idx_q[SW-1:0];
  assign idx_ok    = ({1'b0, idx_q} < (dss_pkg::IDX_W + 1)'(NS));
  assign new_bit   = ~pattern_q[cursor_q][idx_s];
  assign tempo_sum = {1'b0, tempo_q} + {1'b0, dss_pkg::TEMPO_STEP};

  always_comb begin
    pattern_d = pattern_q;
    tempo_d   = tempo_q;
    cursor_d  = cursor_q;
    pos_d     = pos_q;
    running_d = running_q;
    elapsed_d = elapsed_q;
    trig_d    = '0;
    case (op_q)
      dss_pkg::OP_TICK: begin
        if (running_q) begin
          if (elapsed_inc >= {1'b0, period_q}) begin
            elapsed_d = '0;
            pos_d     = pos_wrap;
            trig_d    = col_mask;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      dss_pkg::OP_TOGGLE: begin
        if (idx_ok) begin
          pattern_d[cursor_q][idx_s] = new_bit;
          if (new_bit) trig_d = cursor_onehot;
        end
      end
      dss_pkg::OP_START_STOP: begin
        running_d = ~running_q;
        pos_d     = '0;
        elapsed_d = '0;
      end
      dss_pkg::OP_TRACK_UP: begin
        cursor_d = (cursor_q == '0) ? TW'(NT - 1) : cursor_q - 1'b1;
      end
      dss_pkg::OP_TRACK_DOWN: begin
        cursor_d = (cursor_q == TW'(NT - 1)) ? '0 : cursor_q + 1'b1;
      end
      dss_pkg::OP_TEMPO_UP: begin
        tempo_d = (tempo_sum > {1'b0, dss_pkg::TEMPO_MAX}) ? dss_pkg::TEMPO_MAX
                                                           : tempo_sum[dss_pkg::TEMPO_W-1:0];
      end
      dss_pkg::OP_TEMPO_DOWN: begin
        tempo_d = (tempo_q < dss_pkg::TEMPO_FLOOR) ? dss_pkg::TEMPO_MIN
                                                   : tempo_q - dss_pkg::TEMPO_STEP;
      end
      dss_pkg::OP_CLEAR: begin
        for (int t = 0; t < NT; t++) pattern_d[t] = '0;
      end
      default: begin
        trig_d = '0;
      end
    endcase
  end

  // Restoring divide, one quotient bit per cycle, divisor is the new tempo
  assign trial      = {rem_q, dq_q[dss_pkg::DIVIDEND_W-1]};
  assign trial_ge   = (trial >= {1'b0, tempo_q});
  assign trial_diff = trial - {1'b0, tempo_q};

  always_comb begin
    rem_d = trial_ge ? trial_diff[dss_pkg::TEMPO_W-1:0] : trial[dss_pkg::TEMPO_W-1:0];
    dq_d  = {dq_q[dss_pkg::DIVIDEND_W-2:0], trial_ge};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dq_q  <= dss_pkg::DIVIDEND;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NT; t++) begin
        pattern_q[t] <= dss_pkg::DEFAULT_ROWS[t % 8][NS-1:0];
      end
      tempo_q   <= dss_pkg::TEMPO_RESET;
      period_q  <= dss_pkg::PERIOD_RESET;
      cursor_q  <= '0;
      pos_q     <= '0;
      running_q <= 1'b0;
      elapsed_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        pattern_q <= pattern_d;
        tempo_q   <= tempo_d;
        cursor_q  <= cursor_d;
        pos_q     <= pos_d;
        running_q <= running_d;
        elapsed_q <= elapsed_d;
      end
      if (cmd_i.div_step && status_o.div_last) begin
        period_q <= dq_d[dss_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) trig_q <= trig_d;
  end

  assign mask_ext = dss_pkg::MASK_EXT_W'(trig_q);
  assign trk_ext  = dss_pkg::TRK_EXT_W'(cursor_q);
  assign step_ext = dss_pkg::STEP_EXT_W'(pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      trigger_mask_o   <= mask_ext[dss_pkg::MASK_OUT_W-1:0];
      current_step_o   <= step_ext[dss_pkg::STEP_OUT_W-1:0];
      running_o        <= running_q;
      selected_track_o <= trk_ext[dss_pkg::TRK_OUT_W-1:0];
      tempo_bpm_o      <= tempo_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/drum_step_sequencer.sv -----
// Channel | Handshake              | Fields
// --------+------------------------+------------------------------------------------
// in      | in_valid_i / in_ready_o   | operation_i, step_index_i
// out     | out_valid_o / out_ready_i | trigger_mask_o, current_step_o, running_o,
//         |                           | selected_track_o, tempo_bpm_o
//
// One item at a time: accept, execute, then the result register loads; tempo up/down
// run the bit-serial period divide between execute and the load (states EXEC, DIV,
// FINISH; other operations go from EXEC straight to FINISH).
// Reset loads the default beat, tempo 100 and period 300; no clearing pass.
// A result that is not taken stalls the next item in its final cycle; a new item is
// still accepted while the previous result waits.
`default_nettype none

module drum_step_sequencer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [dss_pkg::OP_W-1:0]         operation_i,
  input  wire logic [dss_pkg::IDX_W-1:0]        step_index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [dss_pkg::MASK_OUT_W-1:0]   trigger_mask_o,
  output logic      [dss_pkg::STEP_OUT_W-1:0]   current_step_o,
  output logic                                  running_o,
  output logic      [dss_pkg::TRK_OUT_W-1:0]    selected_track_o,
  output logic      [dss_pkg::TEMPO_W-1:0]      tempo_bpm_o
);

  dss_pkg::cmd_t    cmd;
  dss_pkg::status_t status;

  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dss_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .step_index_i     (step_index_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .trigger_mask_o   (trigger_mask_o),
    .current_step_o   (current_step_o),
    .running_o        (running_o),
    .selected_track_o (selected_track_o),
    .tempo_bpm_o      (tempo_bpm_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/drum_step_sequencer_test.sv -----
module drum_step_sequencer_test;
  import dss_pkg::*;

  localparam int unsigned BPM_LOW      = 60;
  localparam int unsigned BPM_HIGH     = 180;
  localparam int unsigned BPM_STRIDE   = 5;
  localparam int unsigned BPM_START    = 100;
  localparam int unsigned HALF_MINUTE  = 30000;
  localparam int unsigned COUNT_CEIL   = 1023;
  localparam int unsigned NUM_STEPS    = 8;
  localparam int unsigned NUM_TRACKS   = 4;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          REPORT_MAX   = 10;

  typedef struct packed {
    logic [3:0] mask;
    logic [2:0] step;
    logic       run;
    logic [1:0] track;
    logic [7:0] bpm;
  } beat_result_t;

  class beat_score;
    logic [7:0]   rows [NUM_TRACKS];
    int unsigned  bpm;
    int unsigned  period_ms;
    int unsigned  track;
    int unsigned  pos;
    int unsigned  elapsed;
    bit           playing;
    beat_result_t due_q [$];
    int unsigned  mismatches;

    function new();
      rows[0]    = 8'h11;
      rows[1]    = 8'h44;
      rows[2]    = 8'hD5;
      rows[3]    = 8'h49;
      bpm        = BPM_START;
      period_ms  = HALF_MINUTE / BPM_START;
      track      = 0;
      pos        = 0;
      elapsed    = 0;
      playing    = 1'b0;
      mismatches = 0;
    endfunction

    // Work out the result of one accepted operation and queue it.
    function void note_op(op_e op, logic [2:0] idx);
      beat_result_t r;
      logic [3:0]   trig;
      trig = '0;
      case (op)
        OP_TICK: begin
          if (playing) begin
            if (elapsed < COUNT_CEIL) elapsed++;
            if (elapsed >= period_ms) begin
              elapsed = 0;
              pos = (pos + 1) % NUM_STEPS;
              for (int t = 0; t < NUM_TRACKS; t++) trig[t] = rows[t][pos];
            end
          end
        end
        OP_TOGGLE: begin
          rows[track][idx] = ~rows[track][idx];
          if (rows[track][idx]) trig[track] = 1'b1;
        end
        OP_START_STOP: begin
          playing = !playing;
          pos     = 0;
          elapsed = 0;
        end
        OP_TRACK_UP:   track = (track + NUM_TRACKS - 1) % NUM_TRACKS;
        OP_TRACK_DOWN: track = (track + 1) % NUM_TRACKS;
        OP_TEMPO_UP: begin
          bpm       = (bpm + BPM_STRIDE > BPM_HIGH) ? BPM_HIGH : bpm + BPM_STRIDE;
          period_ms = HALF_MINUTE / bpm;
        end
        OP_TEMPO_DOWN: begin
          bpm       = (bpm < BPM_LOW + BPM_STRIDE) ? BPM_LOW : bpm - BPM_STRIDE;
          period_ms = HALF_MINUTE / bpm;
        end
        default: begin
          for (int t = 0; t < NUM_TRACKS; t++) rows[t] = '0;
        end
      endcase
      r.mask  = trig;
      r.step  = pos[2:0];
      r.run   = playing;
      r.track = track[1:0];
      r.bpm   = bpm[7:0];
      due_q.push_back(r);
    endfunction

    function void check_result(beat_result_t got);
      beat_result_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: result with nothing pending: mask=%h step=%0d run=%0b track=%0d bpm=%0d",
                   got.mask, got.step, got.run, got.track, got.bpm);
        return;
      end
      want = due_q.pop_front();
      if (got.mask != want.mask || got.step != want.step || got.run != want.run ||
          got.track != want.track || got.bpm != want.bpm) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: expected mask=%h step=%0d run=%0b track=%0d bpm=%0d",
                   want.mask, want.step, want.run, want.track, want.bpm);
          $display("          actual   mask=%h step=%0d run=%0b track=%0d bpm=%0d",
                   got.mask, got.step, got.run, got.track, got.bpm);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [2:0] operation_i    = '0;
  logic [2:0] step_index_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [3:0] trigger_mask_o;
  logic [2:0] current_step_o;
  logic       running_o;
  logic [1:0] selected_track_o;
  logic [7:0] tempo_bpm_o;

  beat_score sb = new();
  int        live_items = 0;
  bit        send_idle  = 1'b1;
  bit        take_idle  = 1'b1;
  int        quiet_cycles = 0;

  drum_step_sequencer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_op(op_e op, logic [2:0] idx);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
    live_items++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    step_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(op, idx);
  endtask

  // Result side: random back-pressure, then check each transfer.
  initial begin
    int           stall;
    beat_result_t got;
    wait (rst_ni);
    forever begin
      stall = take_idle ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 39) == 0) take_idle = !take_idle;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.mask  = trigger_mask_o;
      got.step  = current_step_o;
      got.run   = running_o;
      got.track = selected_track_o;
      got.bpm   = tempo_bpm_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int len;
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored tick, a toggle off and on at column 0 and one at column 7,
    // selection wrap, tempo floor, a short run and a clear.
    send_op(OP_TICK, 3'd7);
    send_op(OP_TOGGLE, 3'd0);
    send_op(OP_TOGGLE, 3'd0);
    send_op(OP_TOGGLE, 3'd7);
    send_op(OP_TRACK_UP, 3'd0);
    send_op(OP_TOGGLE, 3'd3);
    send_op(OP_TRACK_DOWN, 3'd7);
    send_op(OP_TRACK_DOWN, 3'd0);
    repeat (9) send_op(OP_TEMPO_DOWN, 3'd5);
    send_op(OP_TEMPO_UP, 3'd2);
    send_op(OP_START_STOP, 3'd0);
    send_op(OP_TICK, 3'd0);
    send_op(OP_TICK, 3'd7);
    send_op(OP_CLEAR, 3'd0);
    send_op(OP_TOGGLE, 3'd5);
    send_op(OP_START_STOP, 3'd7);

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Play: start if stopped, nudge tempo mostly upward, then a run of ticks.
        if (!sb.playing) send_op(OP_START_STOP, 3'($urandom));
        repeat ($urandom_range(0, 2))
          send_op(($urandom_range(0, 3) != 0) ? OP_TEMPO_UP : OP_TEMPO_DOWN, 3'($urandom));
        len = $urandom_range(20, 200);
        repeat (len) begin
          if ($urandom_range(0, 24) == 0) send_op(op_e'($urandom_range(1, 7)), 3'($urandom));
          else send_op(OP_TICK, 3'($urandom));
        end
      end else if (pick < 75) begin
        // Sweep tempo one way, often far enough to hit a clamp.
        len = $urandom_range(5, 30);
        k   = $urandom_range(0, 1);
        repeat (len) send_op((k != 0) ? OP_TEMPO_UP : OP_TEMPO_DOWN, 3'($urandom));
      end else if (pick < 90) begin
        len = $urandom_range(4, 12);
        repeat (len) begin
          k = $urandom_range(0, 9);
          if (k < 6) send_op(OP_TOGGLE, 3'($urandom));
          else if (k < 8) send_op(OP_TRACK_UP, 3'($urandom));
          else if (k == 9 && $urandom_range(0, 3) == 0) send_op(OP_CLEAR, 3'($urandom));
          else send_op(OP_TRACK_DOWN, 3'($urandom));
        end
      end else begin
        len = $urandom_range(5, 15);
        repeat (len) send_op(op_e'($urandom_range(0, 7)), 3'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
